/* rtl/sal_pkg.sv */
// ----------------------------------------------------------------------------
// sal_pkg: shared definitions for the set-associative LRU tag lookup
// Field widths, register reset values, register indexes and the
// configuration record used across the lookup core.
// ----------------------------------------------------------------------------
package sal_pkg;

  // Field widths of the channels.
  localparam int ADDR_W        = 32;
  localparam int TAG_W         = 32;
  localparam int OFFSET_BITS_W = 5;
  localparam int INDEX_BITS_W  = 4;
  localparam int WAYS_IN_USE_W = 4;

  // Raw set number before reduction to the storage depth.
  localparam int IDX_RAW_W = (1 << INDEX_BITS_W) - 1;

  // Configuration write channel.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  // Register reset values.
  localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RST = 5'd5;
  localparam logic [INDEX_BITS_W-1:0]  INDEX_BITS_RST  = 4'd6;
  localparam logic [WAYS_IN_USE_W-1:0] WAYS_IN_USE_RST = 4'd8;

  // Default storage geometry.
  localparam int MAX_SETS_DEF = 256;
  localparam int MAX_WAYS_DEF = 8;

  // Current geometry registers.
  typedef struct packed {
    logic [OFFSET_BITS_W-1:0] offset_bits;
    logic [INDEX_BITS_W-1:0]  index_bits;
    logic [WAYS_IN_USE_W-1:0] ways_in_use;
  } cfg_t;

endpackage

/* rtl/sal_intf.sv */
// ----------------------------------------------------------------------------
// sal_intf: channel interfaces of the set-associative LRU tag lookup
// Address input channel, hit result channel and configuration write channel,
// each a valid/ready handshake that moves one word per accept.
// ----------------------------------------------------------------------------
interface sal_addr_if;
  import sal_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface sal_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, output hit, input ready);
  modport sink   (input valid, input hit, output ready);
endinterface

interface sal_cfg_if;
  import sal_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/sal_ram.sv */
// ----------------------------------------------------------------------------
// sal_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module sal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sal_cfg.sv */
// ----------------------------------------------------------------------------
// sal_cfg: geometry registers of the set-associative LRU tag lookup
// Takes one word per accept on the configuration channel; indexes outside
// the register list are accepted and dropped.
// ----------------------------------------------------------------------------
module sal_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  sal_cfg_if.sink       cfg_i,
  output sal_pkg::cfg_t cfg_o
);
  import sal_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;
  logic wr_acc;

  assign cfg_i.ready = 1'b1;
  assign wr_acc      = cfg_i.valid && cfg_i.ready;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_acc) begin
      case (cfg_i.index)
        CFG_OFFSET_BITS: cfg_d.offset_bits = cfg_i.data[OFFSET_BITS_W-1:0];
        CFG_INDEX_BITS:  cfg_d.index_bits  = cfg_i.data[INDEX_BITS_W-1:0];
        CFG_WAYS_IN_USE: cfg_d.ways_in_use = cfg_i.data[WAYS_IN_USE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_bits <= OFFSET_BITS_RST;
      cfg_q.index_bits  <= INDEX_BITS_RST;
      cfg_q.ways_in_use <= WAYS_IN_USE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/sal_lru_update.sv */
// ----------------------------------------------------------------------------
// sal_lru_update: tag compare and LRU rank update for one set
// Compares the lookup tag against every valid way, picks the hit way or the
// fill way, and forms the new valid bits, ranks and tags of the set.
// ----------------------------------------------------------------------------
module sal_lru_update #(
  parameter int MAX_WAYS = sal_pkg::MAX_WAYS_DEF,
  parameter int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  logic [MAX_WAYS-1:0][sal_pkg::TAG_W-1:0]   tags_i,
  input  logic [MAX_WAYS-1:0]                       vld_i,
  input  logic [MAX_WAYS-1:0][RANK_W-1:0]           ranks_i,
  input  logic [sal_pkg::TAG_W-1:0]                 tag_i,
  input  logic [sal_pkg::WAYS_IN_USE_W-1:0]         ways_in_use_i,
  output logic                                      hit_o,
  output logic [MAX_WAYS-1:0][sal_pkg::TAG_W-1:0]   tags_o,
  output logic [MAX_WAYS-1:0]                       vld_o,
  output logic [MAX_WAYS-1:0][RANK_W-1:0]           ranks_o
);
  import sal_pkg::*;

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W = $clog2(MAX_WAYS + 1);
  localparam int WC_W  = (CNT_W > WAYS_IN_USE_W) ? CNT_W : WAYS_IN_USE_W;

  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] best;
  logic [RANK_W-1:0]   match_rank;
  logic [CNT_W-1:0]    count;
  logic [WC_W-1:0]     count_ext;
  logic [WC_W-1:0]     ways_eff;
  logic                evict;
  logic                lru_any;
  logic [WAY_W-1:0]    lru_slot;
  logic                free_any;
  logic [WAY_W-1:0]    free_slot;
  logic [WAY_W-1:0]    slot;

  // Tag match per valid way.
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      match[w] = vld_i[w] && (tags_i[w] == tag_i);
    end
  end

  // Among matching ways the lowest rank wins; on a tie the lowest way wins.
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      best[w] = match[w];
      for (int v = 0; v < MAX_WAYS; v++) begin
        if (v < w) begin
          if (match[v] && !(ranks_i[v] > ranks_i[w])) best[w] = 1'b0;
        end else if (v > w) begin
          if (match[v] && (ranks_i[v] < ranks_i[w])) best[w] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    match_rank = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (best[w]) match_rank = match_rank | ranks_i[w];
    end
  end

  assign hit_o = |match;

  // Effective associativity, clamped to one and to the storage ways.
  assign count     = CNT_W'($countones(vld_i));
  assign count_ext = WC_W'(count);

  always_comb begin
    if (ways_in_use_i == '0) begin
      ways_eff = WC_W'(1);
    end else if (WC_W'(ways_in_use_i) > WC_W'(MAX_WAYS)) begin
      ways_eff = WC_W'(MAX_WAYS);
    end else begin
      ways_eff = WC_W'(ways_in_use_i);
    end
  end

  assign evict = (count_ext >= ways_eff);

  // Fill way on a miss: last way holding the oldest rank, or the first
  // invalid way while the set has room.
  always_comb begin
    lru_any   = 1'b0;
    lru_slot  = '0;
    free_any  = 1'b0;
    free_slot = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (vld_i[w] && (WC_W'(ranks_i[w]) == (count_ext - WC_W'(1)))) begin
        lru_any  = 1'b1;
        lru_slot = WAY_W'(w);
      end
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (!vld_i[w]) begin
        free_any  = 1'b1;
        free_slot = WAY_W'(w);
      end
    end
  end

  always_comb begin
    if (evict) begin
      slot = lru_any ? lru_slot : '0;
    end else begin
      slot = free_any ? free_slot : '0;
    end
  end

  // New contents of the set.
  always_comb begin
    tags_o  = tags_i;
    vld_o   = vld_i;
    ranks_o = ranks_i;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (hit_o) begin
        if (best[w]) begin
          ranks_o[w] = '0;
        end else if (vld_i[w] && (ranks_i[w] < match_rank)) begin
          ranks_o[w] = ranks_i[w] + RANK_W'(1);
        end
      end else begin
        if (WAY_W'(w) == slot) begin
          tags_o[w]  = tag_i;
          vld_o[w]   = 1'b1;
          ranks_o[w] = '0;
        end else if (vld_i[w]) begin
          ranks_o[w] = ranks_i[w] + RANK_W'(1);
        end
      end
    end
  end

endmodule

/* rtl/set_assoc_lru_tag_lookup_core.sv */
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_lookup_core: tag-only set-associative cache, true LRU
// One address word per lookup, one hit word per lookup; the next address
// waits for write-back. With MAX_SETS a power of two a lookup is set read,
// then compare and write-back; otherwise the set-number reduction comes
// first. The hit word is registered and appears the cycle after write-back.
// The tag and metadata RAMs are the only state per line; reset clears one
// valid flop per set, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module set_assoc_lru_tag_lookup_core #(
  parameter int MAX_SETS = sal_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS = sal_pkg::MAX_WAYS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sal_cfg_if.sink    cfg_i,
  sal_addr_if.sink   addr_i,
  sal_hit_if.source  hit_o
);
  import sal_pkg::*;

  localparam int  SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int  RANK_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int  META_W    = MAX_WAYS * (1 + RANK_W);
  localparam bit  SETS_POW2 = ((MAX_SETS & (MAX_SETS - 1)) == 0);
  // Reciprocal for the set-number reduction when the set count is not a
  // power of two; the quotient estimate is low by at most one.
  localparam int  RECIP_SH  = IDX_RAW_W + SET_W;
  localparam int  RECIP_W   = IDX_RAW_W + 1;
  localparam int  RECIP     = (1 << RECIP_SH) / MAX_SETS;
  localparam int  PROD_W    = IDX_RAW_W + RECIP_W;
  localparam int  MQ_W      = IDX_RAW_W + SET_W + 1;
  localparam int  SH_W      = OFFSET_BITS_W + 1;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  cfg_t                 cfg;
  logic [1:0]           state_q, state_d;
  logic                 addr_acc;
  logic                 upd_fire;

  logic [ADDR_W-1:0]    addr_sh;
  logic [IDX_RAW_W-1:0] idx_mask;
  logic [IDX_RAW_W-1:0] dec_v;
  logic [SH_W-1:0]      tag_sh;
  logic [TAG_W-1:0]     dec_tag;
  logic [SET_W-1:0]     set_direct;

  logic [IDX_RAW_W-1:0] v_q;
  logic [TAG_W-1:0]     tag_q;
  logic [IDX_RAW_W-1:0] q_q, q_d;
  logic [PROD_W-1:0]    prod;
  logic [MQ_W-1:0]      qm;
  logic [MQ_W-1:0]      rem_raw;
  logic [MQ_W-1:0]      rem;
  logic [SET_W-1:0]     set_mod;
  logic [SET_W-1:0]     set_q;

  logic                 rd_en;
  logic [SET_W-1:0]     rd_set;
  logic [MAX_SETS-1:0]  row_vld_q;
  logic                 row_rd_q;

  logic [MAX_WAYS*TAG_W-1:0]               tag_rdata;
  logic [META_W-1:0]                       meta_rdata;
  logic [MAX_WAYS-1:0][TAG_W-1:0]          rd_tags;
  logic [MAX_WAYS-1:0]                     rd_vld;
  logic [MAX_WAYS-1:0][RANK_W-1:0]         rd_ranks;
  logic [MAX_WAYS-1:0][TAG_W-1:0]          new_tags;
  logic [MAX_WAYS-1:0]                     new_vld;
  logic [MAX_WAYS-1:0][RANK_W-1:0]         new_ranks;
  logic                                    lookup_hit;

  logic                 hit_vld_q, hit_vld_d;
  logic                 hit_q;

  // Geometry registers.
  sal_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Address decode: raw set number and tag.
  assign addr_sh  = addr_i.address >> cfg.offset_bits;
  assign idx_mask = ~({IDX_RAW_W{1'b1}} << cfg.index_bits);
  assign dec_v    = addr_sh[IDX_RAW_W-1:0] & idx_mask;
  assign tag_sh   = SH_W'(cfg.offset_bits) + SH_W'(cfg.index_bits);
  assign dec_tag  = (tag_sh >= SH_W'(ADDR_W)) ? '0 :
                    (addr_i.address >> tag_sh[OFFSET_BITS_W-1:0]);
  assign set_direct = (MAX_SETS == 1) ? '0 : dec_v[SET_W-1:0];

  // Set-number reduction for a set count that is not a power of two.
  assign prod    = PROD_W'(v_q) * PROD_W'(RECIP);
  assign q_d     = IDX_RAW_W'(prod >> RECIP_SH);
  assign qm      = MQ_W'(q_q) * MQ_W'(MAX_SETS);
  assign rem_raw = MQ_W'(v_q) - qm;
  assign rem     = (rem_raw >= MQ_W'(MAX_SETS)) ? (rem_raw - MQ_W'(MAX_SETS)) : rem_raw;
  assign set_mod = rem[SET_W-1:0];

  // Handshakes.
  assign addr_i.ready = (state_q == ST_IDLE);
  assign addr_acc     = addr_i.valid && addr_i.ready;
  assign upd_fire     = (state_q == ST_UPD) && (!hit_vld_q || hit_o.ready);

  // Sequencer and set read issue.
  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    rd_set  = set_direct;
    case (state_q)
      ST_IDLE: begin
        if (addr_acc) begin
          if (SETS_POW2) begin
            rd_en   = 1'b1;
            state_d = ST_UPD;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        state_d = ST_MOD;
      end
      ST_MOD: begin
        rd_en   = 1'b1;
        rd_set  = set_mod;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (upd_fire) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Lookup payload registers.
  always_ff @(posedge clk_i) begin
    if (addr_acc) begin
      v_q   <= dec_v;
      tag_q <= dec_tag;
    end
    if (state_q == ST_DIV) begin
      q_q <= q_d;
    end
    if (rd_en) begin
      set_q <= rd_set;
    end
  end

  // One valid flop per set; a set never written reads as all lines invalid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      row_rd_q  <= 1'b0;
    end else begin
      if (rd_en) begin
        row_rd_q <= row_vld_q[rd_set];
      end
      if (upd_fire) begin
        row_vld_q[set_q] <= 1'b1;
      end
    end
  end

  // Tag storage, one row of ways per set.
  sal_ram #(
    .WIDTH (MAX_WAYS * TAG_W),
    .DEPTH (MAX_SETS),
    .AW    (SET_W)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (upd_fire && !lookup_hit),
    .waddr_i (set_q),
    .wdata_i (new_tags),
    .re_i    (rd_en),
    .raddr_i (rd_set),
    .rdata_o (tag_rdata)
  );

  // Valid bits and LRU ranks, one row per set.
  sal_ram #(
    .WIDTH (META_W),
    .DEPTH (MAX_SETS),
    .AW    (SET_W)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (upd_fire),
    .waddr_i (set_q),
    .wdata_i ({new_vld, new_ranks}),
    .re_i    (rd_en),
    .raddr_i (rd_set),
    .rdata_o (meta_rdata)
  );

  // Unpack the set; an unwritten set is all invalid with zero ranks.
  assign rd_tags  = tag_rdata;
  assign rd_vld   = row_rd_q ? meta_rdata[META_W-1 -: MAX_WAYS] : '0;
  assign rd_ranks = row_rd_q ? meta_rdata[MAX_WAYS*RANK_W-1:0] : '0;

  sal_lru_update #(
    .MAX_WAYS (MAX_WAYS),
    .RANK_W   (RANK_W)
  ) u_lru_update (
    .tags_i        (rd_tags),
    .vld_i         (rd_vld),
    .ranks_i       (rd_ranks),
    .tag_i         (tag_q),
    .ways_in_use_i (cfg.ways_in_use),
    .hit_o         (lookup_hit),
    .tags_o        (new_tags),
    .vld_o         (new_vld),
    .ranks_o       (new_ranks)
  );

  // Result register.
  always_comb begin
    hit_vld_d = hit_vld_q;
    if (hit_o.ready) hit_vld_d = 1'b0;
    if (upd_fire) hit_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_vld_q <= 1'b0;
    end else begin
      hit_vld_q <= hit_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      hit_q <= lookup_hit;
    end
  end

  assign hit_o.valid = hit_vld_q;
  assign hit_o.hit   = hit_q;

endmodule
